>>> rtl/ppi_pkg.sv
// Shared types, codes and latency constants for the plane-plane intersection unit.
package ppi_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // DIR_FIXED_LAT is the part of the direction path latency that does not grow with the fraction width.
  localparam int DIR_FIXED_LAT = 39;
  localparam int BASE_LAT      = 42;
  localparam int BASE_DIV_QW   = 33;

  localparam logic [1:0] REL_DISJOINT   = 2'd0;
  localparam logic [1:0] REL_COINCIDENT = 2'd1;
  localparam logic [1:0] REL_INTERSECT  = 2'd2;
  localparam logic [1:0] REL_SATURATED  = 2'd3;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef logic signed [31:0] fix_t;

  typedef struct packed {
    fix_t [2:0] n1;
    fix_t [2:0] o1;
    fix_t [2:0] n2;
    fix_t [2:0] o2;
  } planes_t;

  typedef struct packed {
    logic [2:0] csign;
    logic       par;
    logic       dzero;
  } flags_t;

  typedef struct packed {
    logic [1:0] relation;
    fix_t [2:0] dir;
    fix_t [2:0] base;
  } line_t;

endpackage

>>> rtl/ppi_in_if.sv
// Input channel carrying one pair of planes per transaction.
interface ppi_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] first_normal_x;
  logic signed [31:0] first_normal_y;
  logic signed [31:0] first_normal_z;
  logic signed [31:0] first_origin_x;
  logic signed [31:0] first_origin_y;
  logic signed [31:0] first_origin_z;
  logic signed [31:0] second_normal_x;
  logic signed [31:0] second_normal_y;
  logic signed [31:0] second_normal_z;
  logic signed [31:0] second_origin_x;
  logic signed [31:0] second_origin_y;
  logic signed [31:0] second_origin_z;

  modport source (
    output valid, first_normal_x, first_normal_y, first_normal_z,
    output first_origin_x, first_origin_y, first_origin_z,
    output second_normal_x, second_normal_y, second_normal_z,
    output second_origin_x, second_origin_y, second_origin_z,
    input  ready
  );

  modport sink (
    input  valid, first_normal_x, first_normal_y, first_normal_z,
    input  first_origin_x, first_origin_y, first_origin_z,
    input  second_normal_x, second_normal_y, second_normal_z,
    input  second_origin_x, second_origin_y, second_origin_z,
    output ready
  );
endinterface

>>> rtl/ppi_out_if.sv
// Output channel carrying one intersection line per transaction.
interface ppi_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        relation;
  logic signed [31:0] direction_x;
  logic signed [31:0] direction_y;
  logic signed [31:0] direction_z;
  logic signed [31:0] base_x;
  logic signed [31:0] base_y;
  logic signed [31:0] base_z;

  modport source (
    output valid, relation, direction_x, direction_y, direction_z,
    output base_x, base_y, base_z,
    input  ready
  );

  modport sink (
    input  valid, relation, direction_x, direction_y, direction_z,
    input  base_x, base_y, base_z,
    output ready
  );
endinterface

>>> rtl/ppi_delay.sv
// Enable-gated shift line that keeps side data aligned with a pipeline.
module ppi_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign dout = line[DEPTH-1];

endmodule

>>> rtl/ppi_div.sv
// Pipelined restoring divider producing one quotient bit per stage.
module ppi_div #(
  parameter int QW = 33,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem0,
  input  logic [QW-1:0] low,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_in = rem0;
      assign low_in = low;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= take ? DW'(trial - {1'b0, den_in}) : DW'(trial);
        low_q[s] <= low_in << 1;
        den_q[s] <= den_in;
        quo_q[s] <= {quo_in[QW-2:0], take};
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

>>> rtl/ppi_isqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per stage.
module ppi_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] val,
  output logic [31:0] root
);

  logic [63:0] v_q [32];
  logic [63:0] r_q [32];

  for (genvar s = 0; s < 32; s++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
    logic [63:0] v_in;
    logic [63:0] r_in;
    logic [63:0] trial;
    logic        take;

    if (s == 0) begin : g_first
      assign v_in = val;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[s-1];
      assign r_in = r_q[s-1];
    end

    assign trial = r_in + BIT;
    assign take  = v_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        v_q[s] <= take ? v_in - trial : v_in;
        r_q[s] <= take ? (r_in >> 1) + BIT : r_in >> 1;
      end
    end
  end

  assign root = r_q[31][31:0];

endmodule

>>> rtl/ppi_dir.sv
// Direction path: normalizes the cross product, takes its norm and divides to unit length.
module ppi_dir #(
  parameter int FRAC_BITS = ppi_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [2:0][63:0]           mag,
  output logic [2:0][FRAC_BITS:0]    quo
);

  localparam int NW = 32 + FRAC_BITS;

  function automatic logic [4:0] bitlen16(input logic [15:0] x);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

  logic [63:0]           orv;
  logic [2:0][63:0]      mag1;
  logic [3:0][4:0]       bl1;
  logic [2:0][63:0]      mag2;
  logic [6:0]            m2;
  logic [2:0][30:0]      s3;
  logic [2:0][30:0]      s4;
  logic [2:0][61:0]      sq4;
  logic [2:0][30:0]      s5;
  logic [63:0]           sum5;
  logic [31:0]           norm;
  logic [2:0][30:0]      s_al;
  logic [NW-1:0]         nume [3];
  logic [2:0][31:0]      rem6;
  logic [2:0][FRAC_BITS:0] low6;
  logic [31:0]           norm6;

  assign orv = mag[0] | mag[1] | mag[2];

  always_ff @(posedge clk) begin
    if (en) begin
      mag1 <= mag;
      for (int c = 0; c < 4; c++) begin
        bl1[c] <= bitlen16(orv[16*c +: 16]);
      end

      mag2 <= mag1;
      if (bl1[3] != '0) begin
        m2 <= 7'd48 + 7'(bl1[3]);
      end else if (bl1[2] != '0) begin
        m2 <= 7'd32 + 7'(bl1[2]);
      end else if (bl1[1] != '0) begin
        m2 <= 7'd16 + 7'(bl1[1]);
      end else begin
        m2 <= 7'(bl1[0]);
      end

      for (int i = 0; i < 3; i++) begin
        if (m2 > 7'd31) begin
          s3[i] <= 31'(mag2[i] >> (m2 - 7'd31));
        end else begin
          s3[i] <= 31'(mag2[i] << (7'd31 - m2));
        end
      end

      s4 <= s3;
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= 62'(s3[i]) * 62'(s3[i]);
      end

      s5   <= s4;
      sum5 <= 64'(sq4[0]) + 64'(sq4[1]) + 64'(sq4[2]);
    end
  end

  ppi_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .val  (sum5),
    .root (norm)
  );

  ppi_delay #(.W(93), .DEPTH(32)) u_s_delay (
    .clk  (clk),
    .en   (en),
    .din  (s5),
    .dout (s_al)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nume[i] = (NW'(s_al[i]) << FRAC_BITS) + NW'(norm >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm6 <= norm;
      for (int i = 0; i < 3; i++) begin
        rem6[i] <= 32'(nume[i] >> (FRAC_BITS + 1));
        low6[i] <= nume[i][FRAC_BITS:0];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    ppi_div #(.QW(FRAC_BITS + 1), .DW(32)) u_div (
      .clk  (clk),
      .en   (en),
      .rem0 (rem6[i]),
      .low  (low6[i]),
      .den  (norm6),
      .quo  (quo[i])
    );
  end

endmodule

>>> rtl/ppi_base.sv
// Base point path: picks the zeroed axis, forms the Cramer numerators and divides with rounding.
module ppi_base (
  input  logic                  clk,
  input  logic                  en,
  input  ppi_pkg::planes_t      pl,
  input  logic [2:0][63:0]      mag,
  input  logic [2:0]            csign,
  output logic [2:0][31:0]      base,
  output logic                  sat
);

  localparam int QW = ppi_pkg::BASE_DIV_QW;

  function automatic logic [32:0] finish(input logic [32:0] q, input logic ovf,
                                         input logic neg);
    logic        s;
    logic [31:0] v;
    if (neg) begin
      s = ovf | q[32] | (q[31] & (|q[30:0]));
      v = s ? 32'h8000_0000 : -q[31:0];
    end else begin
      s = ovf | q[32] | q[31];
      v = s ? 32'h7FFF_FFFF : q[31:0];
    end
    return {s, v};
  endfunction

  ppi_pkg::axis_t     axis_c;
  ppi_pkg::axis_t     axis1, axis2, axis3, axis4, axis5, axis6, axis7, axis8, axis_end;
  ppi_pkg::planes_t   pl1;
  logic [2:0][63:0]   mag1;
  logic [2:0]         cs1;
  logic signed [63:0] pr1a [3];
  logic signed [63:0] pr1b [3];
  logic [1:0]         jj, kk;

  logic signed [65:0] d1_2, d2_2;
  logic signed [31:0] n1j2, n1k2, n2j2, n2k2;
  logic [63:0]        dabs2, dabs3, dabs4, dabs5, dabs6, dabs7, dabs8;
  logic               cneg2, cneg3, cneg4, cneg5;

  logic signed [65:0] dsel [4];
  logic signed [31:0] nsel [4];
  logic signed [65:0] lo3 [4];
  logic signed [64:0] hi3 [4];
  logic signed [98:0] full4 [4];
  logic signed [99:0] num5 [2];
  logic [99:0]        nabs6 [2];
  logic [1:0]         nneg6, nneg7, nneg8, nneg_end;
  logic [100:0]       nsum7 [2];
  logic [1:0]         ovf8, ovf_end;
  logic [63:0]        rem8 [2];
  logic [32:0]        low8 [2];
  logic [32:0]        quo_j, quo_k;
  logic [5:0]         side_end;
  logic [32:0]        fin_j, fin_k;

  always_comb begin
    if (mag[0] > mag[1] && mag[0] > mag[2]) begin
      axis_c = ppi_pkg::AXIS_X;
    end else if (mag[1] > mag[2]) begin
      axis_c = ppi_pkg::AXIS_Y;
    end else begin
      axis_c = ppi_pkg::AXIS_Z;
    end
  end

  always_comb begin
    unique case (axis1)
      ppi_pkg::AXIS_X: begin
        jj = ppi_pkg::AXIS_Y;
        kk = ppi_pkg::AXIS_Z;
      end
      ppi_pkg::AXIS_Y: begin
        jj = ppi_pkg::AXIS_Z;
        kk = ppi_pkg::AXIS_X;
      end
      ppi_pkg::AXIS_Z: begin
        jj = ppi_pkg::AXIS_X;
        kk = ppi_pkg::AXIS_Y;
      end
      default: begin
        jj = ppi_pkg::AXIS_Y;
        kk = ppi_pkg::AXIS_Z;
      end
    endcase
  end

  assign dsel[0] = d2_2;
  assign dsel[1] = d1_2;
  assign dsel[2] = d1_2;
  assign dsel[3] = d2_2;
  assign nsel[0] = n1k2;
  assign nsel[1] = n2k2;
  assign nsel[2] = n2j2;
  assign nsel[3] = n1j2;

  always_ff @(posedge clk) begin
    if (en) begin
      axis1 <= axis_c;
      pl1   <= pl;
      mag1  <= mag;
      cs1   <= csign;
      for (int i = 0; i < 3; i++) begin
        pr1a[i] <= $signed(pl.n1[i]) * $signed(pl.o1[i]);
        pr1b[i] <= $signed(pl.n2[i]) * $signed(pl.o2[i]);
      end

      axis2 <= axis1;
      d1_2  <= -(66'(pr1a[0]) + 66'(pr1a[1]) + 66'(pr1a[2]));
      d2_2  <= -(66'(pr1b[0]) + 66'(pr1b[1]) + 66'(pr1b[2]));
      n1j2  <= $signed(pl1.n1[jj]);
      n1k2  <= $signed(pl1.n1[kk]);
      n2j2  <= $signed(pl1.n2[jj]);
      n2k2  <= $signed(pl1.n2[kk]);
      dabs2 <= mag1[axis1];
      cneg2 <= cs1[axis1];

      axis3 <= axis2;
      dabs3 <= dabs2;
      cneg3 <= cneg2;
      for (int p = 0; p < 4; p++) begin
        lo3[p] <= $signed({1'b0, dsel[p][32:0]}) * $signed(nsel[p]);
        hi3[p] <= $signed(dsel[p][65:33]) * $signed(nsel[p]);
      end

      axis4 <= axis3;
      dabs4 <= dabs3;
      cneg4 <= cneg3;
      for (int p = 0; p < 4; p++) begin
        full4[p] <= (99'(hi3[p]) <<< 33) + 99'(lo3[p]);
      end

      axis5   <= axis4;
      dabs5   <= dabs4;
      cneg5   <= cneg4;
      num5[0] <= 100'(full4[0]) - 100'(full4[1]);
      num5[1] <= 100'(full4[2]) - 100'(full4[3]);

      axis6 <= axis5;
      dabs6 <= dabs5;
      for (int q = 0; q < 2; q++) begin
        nabs6[q] <= num5[q][99] ? 100'(-num5[q]) : 100'(num5[q]);
        nneg6[q] <= num5[q][99] ^ cneg5;
      end

      axis7 <= axis6;
      dabs7 <= dabs6;
      nneg7 <= nneg6;
      for (int q = 0; q < 2; q++) begin
        nsum7[q] <= 101'(nabs6[q]) + 101'(dabs6 >> 1);
      end

      axis8 <= axis7;
      dabs8 <= dabs7;
      nneg8 <= nneg7;
      for (int q = 0; q < 2; q++) begin
        ovf8[q] <= nsum7[q] >= {4'b0, dabs7, 33'b0};
        rem8[q] <= nsum7[q][96:33];
        low8[q] <= nsum7[q][32:0];
      end
    end
  end

  ppi_div #(.QW(QW), .DW(64)) u_div_j (
    .clk  (clk),
    .en   (en),
    .rem0 (rem8[0]),
    .low  (low8[0]),
    .den  (dabs8),
    .quo  (quo_j)
  );

  ppi_div #(.QW(QW), .DW(64)) u_div_k (
    .clk  (clk),
    .en   (en),
    .rem0 (rem8[1]),
    .low  (low8[1]),
    .den  (dabs8),
    .quo  (quo_k)
  );

  ppi_delay #(.W(6), .DEPTH(QW)) u_side (
    .clk  (clk),
    .en   (en),
    .din  ({axis8, ovf8, nneg8}),
    .dout (side_end)
  );

  assign axis_end = ppi_pkg::axis_t'(side_end[5:4]);
  assign ovf_end  = side_end[3:2];
  assign nneg_end = side_end[1:0];
  assign fin_j    = finish(quo_j, ovf_end[0], nneg_end[0]);
  assign fin_k    = finish(quo_k, ovf_end[1], nneg_end[1]);

  always_ff @(posedge clk) begin
    if (en) begin
      sat <= fin_j[32] | fin_k[32];
      unique case (axis_end)
        ppi_pkg::AXIS_X: base <= {fin_k[31:0], fin_j[31:0], 32'd0};
        ppi_pkg::AXIS_Y: base <= {fin_j[31:0], 32'd0, fin_k[31:0]};
        ppi_pkg::AXIS_Z: base <= {32'd0, fin_k[31:0], fin_j[31:0]};
        default:         base <= '0;
      endcase
    end
  end

endmodule

>>> rtl/plane_plane_intersection_unit.sv
// Top level of the plane-plane intersection unit: cross product front end, path merge, output queue.
// The unit takes one pair of planes per cycle and returns one line per pair, in order, in the
// Q16.16 format at the default FRAC_BITS. The latency is set by the direction
// path: a 32-stage square root of the squared norm followed by a divider of FRAC_BITS + 1 stages;
// the base point path, with its 33-stage rounding dividers, runs alongside it and is padded to
// match. Results land in a two-entry output queue, so a transaction can be taken while one line
// waits; the whole pipeline holds only when that queue is full.
module plane_plane_intersection_unit #(
  parameter int FRAC_BITS = ppi_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ppi_in_if.sink     plane_in,
  ppi_out_if.source  line_out
);

  localparam int DIR_LAT  = ppi_pkg::DIR_FIXED_LAT + FRAC_BITS;
  localparam int PIPE_LAT = 3 + DIR_LAT;
  localparam int BASE_PAD = DIR_LAT - ppi_pkg::BASE_LAT;

  logic                    en;
  logic [PIPE_LAT-1:0]     vld;
  ppi_pkg::planes_t        in_pl, pl1, pl2, pl3;
  logic signed [63:0]      xp_a [3];
  logic signed [63:0]      xp_b [3];
  logic signed [32:0]      diff1 [3];
  logic signed [64:0]      c2 [3];
  logic signed [64:0]      dotp2 [3];
  logic signed [66:0]      dsum;
  logic [2:0][63:0]        mag3;
  ppi_pkg::flags_t         fl3, fl_end;
  logic [2:0][FRAC_BITS:0] dir_q;
  logic [2:0][31:0]        base_b;
  logic                    sat_b;
  logic [96:0]             base_pad;
  ppi_pkg::line_t          res;
  ppi_pkg::line_t          fifo_mem [2];
  logic                    wr_ptr, rd_ptr;
  logic [1:0]              count;
  logic                    wr_en, rd_en;

  assign en             = count != 2'd2;
  assign plane_in.ready = en;

  always_comb begin
    in_pl.n1[0] = plane_in.first_normal_x;
    in_pl.n1[1] = plane_in.first_normal_y;
    in_pl.n1[2] = plane_in.first_normal_z;
    in_pl.o1[0] = plane_in.first_origin_x;
    in_pl.o1[1] = plane_in.first_origin_y;
    in_pl.o1[2] = plane_in.first_origin_z;
    in_pl.n2[0] = plane_in.second_normal_x;
    in_pl.n2[1] = plane_in.second_normal_y;
    in_pl.n2[2] = plane_in.second_normal_z;
    in_pl.o2[0] = plane_in.second_origin_x;
    in_pl.o2[1] = plane_in.second_origin_y;
    in_pl.o2[2] = plane_in.second_origin_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], plane_in.valid};
    end
  end

  assign dsum = 67'(dotp2[0]) + 67'(dotp2[1]) + 67'(dotp2[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      pl1     <= in_pl;
      xp_a[0] <= $signed(in_pl.n1[1]) * $signed(in_pl.n2[2]);
      xp_b[0] <= $signed(in_pl.n1[2]) * $signed(in_pl.n2[1]);
      xp_a[1] <= $signed(in_pl.n1[2]) * $signed(in_pl.n2[0]);
      xp_b[1] <= $signed(in_pl.n1[0]) * $signed(in_pl.n2[2]);
      xp_a[2] <= $signed(in_pl.n1[0]) * $signed(in_pl.n2[1]);
      xp_b[2] <= $signed(in_pl.n1[1]) * $signed(in_pl.n2[0]);
      for (int i = 0; i < 3; i++) begin
        diff1[i] <= $signed(in_pl.o1[i]) - $signed(in_pl.o2[i]);
      end

      pl2 <= pl1;
      for (int i = 0; i < 3; i++) begin
        c2[i]    <= 65'(xp_a[i]) - 65'(xp_b[i]);
        dotp2[i] <= $signed(pl1.n1[i]) * diff1[i];
      end

      pl3       <= pl2;
      fl3.par   <= c2[0] == '0 && c2[1] == '0 && c2[2] == '0;
      fl3.dzero <= dsum == '0;
      for (int i = 0; i < 3; i++) begin
        fl3.csign[i] <= c2[i][64];
        mag3[i]      <= c2[i][64] ? 64'(-c2[i]) : 64'(c2[i]);
      end
    end
  end

  ppi_dir #(.FRAC_BITS(FRAC_BITS)) u_dir (
    .clk (clk),
    .en  (en),
    .mag (mag3),
    .quo (dir_q)
  );

  ppi_base u_base (
    .clk   (clk),
    .en    (en),
    .pl    (pl3),
    .mag   (mag3),
    .csign (fl3.csign),
    .base  (base_b),
    .sat   (sat_b)
  );

  ppi_delay #(.W($bits(ppi_pkg::flags_t)), .DEPTH(DIR_LAT)) u_flag_delay (
    .clk  (clk),
    .en   (en),
    .din  (fl3),
    .dout (fl_end)
  );

  ppi_delay #(.W(97), .DEPTH(BASE_PAD)) u_base_delay (
    .clk  (clk),
    .en   (en),
    .din  ({sat_b, base_b}),
    .dout (base_pad)
  );

  always_comb begin
    if (fl_end.par) begin
      res.relation = fl_end.dzero ? ppi_pkg::REL_COINCIDENT : ppi_pkg::REL_DISJOINT;
      res.dir      = '0;
      res.base     = '0;
    end else begin
      res.relation = base_pad[96] ? ppi_pkg::REL_SATURATED : ppi_pkg::REL_INTERSECT;
      for (int i = 0; i < 3; i++) begin
        res.dir[i] = fl_end.csign[i] ? -32'(dir_q[i]) : 32'(dir_q[i]);
      end
      res.base = base_pad[95:0];
    end
  end

  assign wr_en = en && vld[PIPE_LAT-1];
  assign rd_en = line_out.valid && line_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_mem[wr_ptr] <= res;
    end
  end

  assign line_out.valid       = count != 2'd0;
  assign line_out.relation    = fifo_mem[rd_ptr].relation;
  assign line_out.direction_x = fifo_mem[rd_ptr].dir[0];
  assign line_out.direction_y = fifo_mem[rd_ptr].dir[1];
  assign line_out.direction_z = fifo_mem[rd_ptr].dir[2];
  assign line_out.base_x      = fifo_mem[rd_ptr].base[0];
  assign line_out.base_y      = fifo_mem[rd_ptr].base[1];
  assign line_out.base_z      = fifo_mem[rd_ptr].base[2];

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("Output queue count exceeded its depth.");

  a_parallel_zero: assert property (@(posedge clk) disable iff (rst)
    line_out.valid && (line_out.relation == ppi_pkg::REL_DISJOINT ||
                       line_out.relation == ppi_pkg::REL_COINCIDENT)
    |-> line_out.direction_x == '0 && line_out.direction_y == '0 &&
        line_out.direction_z == '0 && line_out.base_x == '0 &&
        line_out.base_y == '0 && line_out.base_z == '0)
    else $error("Parallel result carries a nonzero direction or base point.");

  a_dir_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_out.valid && (line_out.relation == ppi_pkg::REL_INTERSECT ||
                       line_out.relation == ppi_pkg::REL_SATURATED)
    |-> (line_out.direction_x != '0 || line_out.direction_y != '0 ||
         line_out.direction_z != '0))
    else $error("Intersecting result has a zero direction.");

endmodule
